FILE: sv/sparse_matvec_csr_macros.svh
// Assertion helpers used by the checker of the sparse product block.
`ifndef SPARSE_MATVEC_CSR_MACROS_SVH
`define SPARSE_MATVEC_CSR_MACROS_SVH

// Checked out of reset only
`define SMV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included
`define SMV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: sv/smv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package smv_pkg;

  // Field widths
  localparam int unsigned IndexW    = 10;
  localparam int unsigned DataW     = 32;
  localparam int unsigned AccW      = 64;
  localparam int unsigned RowW      = 10;
  localparam int unsigned RowCountW = 11;

  // Default store depth and row counter limits
  localparam int unsigned VectorDepthDefault = 1024;
  localparam logic [RowCountW-1:0] RowCountReset = 11'd1024;
  localparam logic [RowCountW-1:0] RowLimit      = 11'd1024;

  // Request operation codes
  typedef enum logic [1:0] {
    OpLoad    = 2'd0,
    OpNonzero = 2'd1,
    OpEmpty   = 2'd2
  } op_e;

  // Item handed to the multiply-accumulate unit
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] elem;
    logic                    add;
    logic                    emit;
  } mac_item_t;

  // Finished row, before conversion to Q16.16
  typedef struct packed {
    logic [AccW-1:0] sum;
    logic            sat;
    logic [RowW-1:0] row;
  } emit_t;

endpackage

`default_nettype wire

FILE: sv/smv_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: vector loads, nonzeros and empty rows
interface smv_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             op;
  logic [smv_pkg::IndexW-1:0]             index;
  logic signed [smv_pkg::DataW-1:0]       value;
  logic                                   last_in_row;

  modport source (output valid, op, index, value, last_in_row, input ready);
  modport sink   (input valid, op, index, value, last_in_row, output ready);
endinterface

// Result channel: one row sum per closed row
interface smv_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic [smv_pkg::RowW-1:0]               row_index;
  logic signed [smv_pkg::DataW-1:0]       row_sum;
  logic                                   saturated;

  modport source (output valid, row_index, row_sum, saturated, input ready);
  modport sink   (input valid, row_index, row_sum, saturated, output ready);
endinterface

`default_nettype wire

FILE: sv/smv_vec_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Dense vector store: one write port, one registered read port
module smv_vec_store #(
  parameter int unsigned Depth = smv_pkg::VectorDepthDefault,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [AddrW-1:0]         waddr_i,
  input  wire logic [smv_pkg::DataW-1:0] wdata_i,
  input  wire logic                     re_i,
  input  wire logic [AddrW-1:0]         raddr_i,
  output logic      [smv_pkg::DataW-1:0] rdata_o
);

  logic [smv_pkg::DataW-1:0] mem [Depth];
  logic [smv_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/smv_mac.sv
`timescale 1ns / 1ps
`default_nettype none

// Product stage, saturating accumulator, row counter and row hand-off
module smv_mac (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [smv_pkg::RowCountW-1:0] row_count_i,
  input  wire logic                          in_valid_i,
  input  wire smv_pkg::mac_item_t            in_item_i,
  output logic                               in_ready_o,
  output logic                               emit_valid_o,
  output smv_pkg::emit_t                     emit_o,
  input  wire logic                          emit_ready_i
);

  localparam int unsigned AccW = smv_pkg::AccW;
  localparam logic [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  logic                  s2_v_q, s2_v_d;
  logic signed [AccW-1:0] s2_prod_q, s2_prod_d;
  logic                  s2_emit_q;
  logic [AccW-1:0]       acc_q, acc_d;
  logic                  ovf_q, ovf_d;
  logic [smv_pkg::RowW-1:0] row_q, row_d;
  logic                  s3_v_q, s3_v_d;
  smv_pkg::emit_t        s3_q, s3_d;

  logic                  s3_free, s2_go;
  logic [AccW:0]         sum_ext;
  logic                  add_ovf;
  logic [AccW-1:0]       acc_new;
  logic [smv_pkg::RowCountW-1:0] row_inc;

  // handshake between stages
  assign s3_free    = !s3_v_q || emit_ready_i;
  assign s2_go      = s2_v_q && (!s2_emit_q || s3_free);
  assign in_ready_o = !s2_v_q || s2_go;

  // exact Q32.32 product; empty rows add nothing
  always_comb begin
    s2_prod_d = '0;
    if (in_item_i.add) begin
      s2_prod_d = AccW'(in_item_i.value * in_item_i.elem);
    end
  end

  // saturating 64-bit accumulate
  assign sum_ext = {acc_q[AccW-1], acc_q} + {s2_prod_q[AccW-1], s2_prod_q};
  assign add_ovf = sum_ext[AccW] ^ sum_ext[AccW-1];
  assign acc_new = add_ovf ? (sum_ext[AccW] ? AccMin : AccMax) : sum_ext[AccW-1:0];

  // row counter wraps at row_count, and never passes 1024
  assign row_inc = {1'b0, row_q} + smv_pkg::RowCountW'(1);

  always_comb begin
    acc_d  = acc_q;
    ovf_d  = ovf_q;
    row_d  = row_q;
    s3_d   = s3_q;
    s2_v_d = s2_v_q;
    s3_v_d = s3_v_q;
    if (in_ready_o) begin
      s2_v_d = in_valid_i;
    end
    if (s3_free) begin
      s3_v_d = s2_go && s2_emit_q;
    end
    if (s2_go) begin
      if (s2_emit_q) begin
        acc_d    = '0;
        ovf_d    = 1'b0;
        s3_d.sum = acc_new;
        s3_d.sat = ovf_q | add_ovf;
        s3_d.row = row_q;
        if (row_inc >= row_count_i || row_inc >= smv_pkg::RowLimit) begin
          row_d = '0;
        end else begin
          row_d = row_inc[smv_pkg::RowW-1:0];
        end
      end else begin
        acc_d = acc_new;
        ovf_d = ovf_q | add_ovf;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      acc_q  <= '0;
      ovf_q  <= 1'b0;
      row_q  <= '0;
    end else begin
      s2_v_q <= s2_v_d;
      s3_v_q <= s3_v_d;
      acc_q  <= acc_d;
      ovf_q  <= ovf_d;
      row_q  <= row_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s2_prod_q <= s2_prod_d;
      s2_emit_q <= in_item_i.emit;
    end
    s3_q <= s3_d;
  end

  assign emit_valid_o = s3_v_q;
  assign emit_o       = s3_q;

endmodule

`default_nettype wire

FILE: sv/smv_round.sv
`timescale 1ns / 1ps
`default_nettype none

// Q32.32 to Q16.16 rounding and clamping into the output register
module smv_round (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire smv_pkg::emit_t in_i,
  output logic                in_ready_o,
  smv_rsp_if.source           rsp_o
);

  localparam int unsigned DataW = smv_pkg::DataW;
  localparam int unsigned QW    = smv_pkg::AccW - 15;   // 48 bits plus sign guard

  logic                   out_v_q, out_v_d;
  logic [smv_pkg::RowW-1:0] row_q;
  logic [DataW-1:0]       sum_q, sum_d;
  logic                   sat_q, sat_d;

  logic [QW-1:0]          q_rnd;
  logic                   pos_clamp, neg_clamp;

  assign in_ready_o = !out_v_q || rsp_o.ready;

  // add half an LSB then floor, in 49 bits
  assign q_rnd = {in_i.sum[smv_pkg::AccW-1], in_i.sum[smv_pkg::AccW-1:16]}
               + QW'(in_i.sum[15]);
  assign pos_clamp = !q_rnd[QW-1] && (q_rnd[QW-2:DataW-1] != '0);
  assign neg_clamp =  q_rnd[QW-1] && (q_rnd[QW-2:DataW-1] != '1);

  always_comb begin
    sat_d = in_i.sat | pos_clamp | neg_clamp;
    if (pos_clamp) begin
      sum_d = {1'b0, {(DataW-1){1'b1}}};
    end else if (neg_clamp) begin
      sum_d = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      sum_d = q_rnd[DataW-1:0];
    end
  end

  always_comb begin
    out_v_d = out_v_q;
    if (in_ready_o) begin
      out_v_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      row_q <= in_i.row;
      sum_q <= sum_d;
      sat_q <= sat_d;
    end
  end

  assign rsp_o.valid     = out_v_q;
  assign rsp_o.row_index = row_q;
  assign rsp_o.row_sum   = sum_q;
  assign rsp_o.saturated = sat_q;

endmodule

`default_nettype wire

FILE: sv/sparse_matvec_csr.sv
// Sparse matrix times dense vector, rows in compressed sparse row order.
// Requests on req_i: op OpLoad writes value into vector element index;
// op OpNonzero multiplies value (Q16.16) by the element at column index and
// adds the exact Q32.32 product into a 64-bit saturating accumulator, and
// with last_in_row set also closes the row; op OpEmpty closes the row with
// no product. Op code 3 is dropped. Loads may come at any time.
// Each closed row gives one response on rsp_o: row number, sum rounded to
// Q16.16 and clamped to 32 bits, and a flag when anything saturated.
// The row number wraps to zero after cfg_data_i rows, and after 1024 at most;
// the row count is 1024 after reset, and the user must write it with cfg_we_i
// only while the block is idle, which the block itself does not enforce.
// Throughput: one request per clock unless the response stalls, set by the
// single read port of the vector store and one multiply-accumulate per cycle.
// A row-closing request goes through store read, multiply, accumulate and round.
// Reset clears the pipeline, accumulator, row number and flag; the vector
// store is undefined until loaded. A stalled receiver holds the response;
// the pipeline fills behind it and req_i.ready falls once it is full.
`timescale 1ns / 1ps
`default_nettype none

module sparse_matvec_csr #(
  parameter int unsigned VectorDepth = smv_pkg::VectorDepthDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [smv_pkg::RowCountW-1:0] cfg_data_i,
  smv_req_if.sink                            req_i,
  smv_rsp_if.source                          rsp_o
);

  localparam int unsigned AddrW = (VectorDepth > 1) ? $clog2(VectorDepth) : 1;
  localparam int unsigned ExtW  = (AddrW > smv_pkg::IndexW) ? AddrW : smv_pkg::IndexW;

  logic [smv_pkg::RowCountW-1:0] row_count_q;

  logic [ExtW-1:0]         idx_ext;
  logic [AddrW-1:0]        addr;
  logic                    in_range;
  logic                    accept;
  logic                    is_load, is_nz, is_empty;

  logic                    s1_free;
  logic                    s1_v_q, s1_v_d;
  logic [smv_pkg::DataW-1:0] s1_value_q;
  logic                    s1_add_q, s1_emit_q, s1_range_q;
  logic [smv_pkg::DataW-1:0] rdata;

  smv_pkg::mac_item_t      mac_item;
  logic                    mac_ready;
  logic                    emit_valid, emit_ready;
  smv_pkg::emit_t          emit;

  // row count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= smv_pkg::RowCountReset;
    end else if (cfg_we_i) begin
      row_count_q <= cfg_data_i;
    end
  end

  // request decode
  assign idx_ext  = ExtW'(req_i.index);
  assign addr     = idx_ext[AddrW-1:0];
  assign in_range = 32'(req_i.index) < VectorDepth;
  assign is_load  = req_i.op == smv_pkg::OpLoad;
  assign is_nz    = req_i.op == smv_pkg::OpNonzero;
  assign is_empty = req_i.op == smv_pkg::OpEmpty;

  assign s1_free     = !s1_v_q || mac_ready;
  assign req_i.ready = s1_free;
  assign accept      = req_i.valid && s1_free;

  smv_vec_store #(
    .Depth (VectorDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (accept && is_load && in_range),
    .waddr_i (addr),
    .wdata_i (req_i.value),
    .re_i    (accept && is_nz && in_range),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  // read stage: only nonzeros and empty rows travel on
  always_comb begin
    s1_v_d = s1_v_q;
    if (s1_free) begin
      s1_v_d = accept && (is_nz || is_empty);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_value_q <= req_i.value;
      s1_add_q   <= is_nz;
      s1_emit_q  <= is_empty || (is_nz && req_i.last_in_row);
      s1_range_q <= in_range;
    end
  end

  // columns beyond the store multiply by zero
  always_comb begin
    mac_item.value = s1_value_q;
    mac_item.elem  = s1_range_q ? rdata : '0;
    mac_item.add   = s1_add_q;
    mac_item.emit  = s1_emit_q;
  end

  smv_mac u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .row_count_i  (row_count_q),
    .in_valid_i   (s1_v_q),
    .in_item_i    (mac_item),
    .in_ready_o   (mac_ready),
    .emit_valid_o (emit_valid),
    .emit_o       (emit),
    .emit_ready_i (emit_ready)
  );

  smv_round u_round (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (emit_valid),
    .in_i       (emit),
    .in_ready_o (emit_ready),
    .rsp_o      (rsp_o)
  );

endmodule

`default_nettype wire

FILE: sv/smv_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "sparse_matvec_csr_macros.svh"

// Port-level checks for the sparse product block
module smv_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          req_ready_i,
  input wire logic                          rsp_valid_i,
  input wire logic                          rsp_ready_i,
  input wire logic [smv_pkg::RowW-1:0]      rsp_row_i,
  input wire logic [smv_pkg::DataW-1:0]     rsp_sum_i,
  input wire logic                          rsp_sat_i
);

  // a held response stays up
  `SMV_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i, "response dropped while stalled")

  // a held response keeps its payload
  `SMV_ASSERT(a_rsp_stable, rsp_valid_i && !rsp_ready_i |=> $stable(rsp_row_i) && $stable(rsp_sum_i) && $stable(rsp_sat_i), "response changed while stalled")

  // back-pressure on requests only comes from a stalled response
  `SMV_ASSERT(a_req_backpressure, !req_ready_i |-> rsp_valid_i && !rsp_ready_i, "request stalled with free output")

  // nothing is offered while in reset
  `SMV_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !rsp_valid_i, "response offered in reset")

endmodule

bind sparse_matvec_csr smv_checker u_smv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_row_i   (rsp_o.row_index),
  .rsp_sum_i   (rsp_o.row_sum),
  .rsp_sat_i   (rsp_o.saturated)
);

`default_nettype wire
